@@ design/ohs_pkg.sv @@
// Shared types and constants for the open-addressing hash set.
// No dependencies; imported by ohs_ctrl and open_addressing_hash_set.
package ohs_pkg;

   // Action codes carried in the low bits of an input item.
   typedef logic [1:0] action_type;
   localparam action_type ACT_ADD    = 2'd0;
   localparam action_type ACT_REMOVE = 2'd1;
   // every other code is a membership query

   // Result status codes.
   typedef enum logic [2:0] {
      ST_ADDED     = 3'd0,
      ST_PRESENT   = 3'd1,
      ST_REMOVED   = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_FOUND     = 3'd4,
      ST_RESERVED  = 3'd5,
      ST_FULL      = 3'd6
   } status_type;

   // Hash multiplier and probe stride.
   localparam int HASH_MUL   = 73;
   localparam int PROBE_STEP = 5009;

   // Finished result handed from the sequencer to the output register.
   typedef struct packed {
      logic       valid;
      status_type status;
   } fin_type;

endpackage

@@ design/ohs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the slot table.
module ohs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/ohs_ctrl.sv @@
// Probe sequencer: clearing pass, hashing, slot-by-slot probing, table update.
// Depends on ohs_pkg; drives the ports of one ohs_ram instance.
module ohs_ctrl #(
   parameter int CAPACITY = 1024,
   parameter int KEY_BITS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  ohs_pkg::action_type             start_action,
   input  logic [KEY_BITS-1:0]             start_key,
   output logic                            idle,
   output ohs_pkg::fin_type                fin,
   input  logic                            fin_take,
   output logic [$clog2(CAPACITY+1)-1:0]   live_count,
   output logic                            ram_we,
   output logic [$clog2(CAPACITY)-1:0]     ram_waddr,
   output logic [KEY_BITS-1:0]             ram_wdata,
   output logic [$clog2(CAPACITY)-1:0]     ram_raddr,
   input  logic [KEY_BITS-1:0]             ram_rdata
);
   import ohs_pkg::*;

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int PW     = ADDR_W + KEY_BITS;
   localparam logic [KEY_BITS-1:0] SLOT_EMPTY = '0;
   localparam logic [KEY_BITS-1:0] SLOT_TOMB  = KEY_BITS'(1);
   localparam logic [ADDR_W-1:0]   STRIDE     = ADDR_W'(PROBE_STEP);
   localparam logic [CNT_W-1:0]    CNT_MAX    = CNT_W'(CAPACITY);

   typedef enum logic [2:0] {
      S_CLR,
      S_IDLE,
      S_RD,
      S_CMP,
      S_FIN
   } state_type;

   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   clr_ff, clr_in;
   logic [ADDR_W-1:0]   idx_ff, idx_in;
   logic [ADDR_W-1:0]   probe_ff, probe_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   action_type          act_ff, act_in;
   status_type          status_ff, status_in;
   logic [CNT_W-1:0]    live_ff, live_in;

   logic [PW-1:0]       hash_prod;
   logic [ADDR_W-1:0]   idx_step;
   logic                start_reserved;
   logic                slot_empty;
   logic                slot_tomb;
   logic                slot_hit;
   logic                last_probe;

   assign hash_prod      = PW'(start_key) * PW'(HASH_MUL);
   assign idx_step       = idx_ff + STRIDE;
   assign start_reserved = (start_key == SLOT_EMPTY) || (start_key == SLOT_TOMB);
   assign slot_empty     = (ram_rdata == SLOT_EMPTY);
   assign slot_tomb      = (ram_rdata == SLOT_TOMB);
   assign slot_hit       = (ram_rdata == key_ff);
   assign last_probe     = &probe_ff;

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      idx_in    = idx_ff;
      probe_in  = probe_ff;
      key_in    = key_ff;
      act_in    = act_ff;
      status_in = status_ff;
      live_in   = live_ff;
      ram_we    = 1'b0;
      ram_waddr = idx_ff;
      ram_wdata = key_ff;
      ram_raddr = idx_ff;
      case (state_ff)
         S_CLR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = SLOT_EMPTY;
            clr_in    = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               key_in   = start_key;
               act_in   = start_action;
               idx_in   = hash_prod[ADDR_W-1:0];
               probe_in = '0;
               if (start_reserved) begin
                  status_in = ST_RESERVED;
                  state_in  = S_FIN;
               end else begin
                  state_in = S_RD;
               end
            end
         end
         S_RD: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            // read the next slot ahead; dropped if this probe ends the search
            ram_raddr = idx_step;
            if (act_ff == ACT_ADD) begin
               if (slot_empty || slot_tomb) begin
                  ram_we    = 1'b1;
                  status_in = ST_ADDED;
                  if (live_ff < CNT_MAX) begin
                     live_in = live_ff + 1'b1;
                  end
                  state_in = S_FIN;
               end else if (slot_hit) begin
                  status_in = ST_PRESENT;
                  state_in  = S_FIN;
               end else if (last_probe) begin
                  status_in = ST_FULL;
                  state_in  = S_FIN;
               end else begin
                  idx_in   = idx_step;
                  probe_in = probe_ff + 1'b1;
               end
            end else begin
               if (slot_empty) begin
                  status_in = ST_NOT_FOUND;
                  state_in  = S_FIN;
               end else if (slot_hit) begin
                  if (act_ff == ACT_REMOVE) begin
                     ram_we    = 1'b1;
                     ram_wdata = SLOT_TOMB;
                     status_in = ST_REMOVED;
                     if (live_ff != '0) begin
                        live_in = live_ff - 1'b1;
                     end
                  end else begin
                     status_in = ST_FOUND;
                  end
                  state_in = S_FIN;
               end else if (last_probe) begin
                  status_in = ST_NOT_FOUND;
                  state_in  = S_FIN;
               end else begin
                  idx_in   = idx_step;
                  probe_in = probe_ff + 1'b1;
               end
            end
         end
         S_FIN: begin
            if (fin_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLR;
            clr_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_ff   <= '0;
         live_ff  <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         live_ff  <= live_in;
      end
      idx_ff    <= idx_in;
      probe_ff  <= probe_in;
      key_ff    <= key_in;
      act_ff    <= act_in;
      status_ff <= status_in;
   end

   assign idle       = (state_ff == S_IDLE);
   assign fin.valid  = (state_ff == S_FIN);
   assign fin.status = status_ff;
   assign live_count = live_ff;

`ifndef SYNTHESIS
   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      live_ff <= CNT_MAX)
      else $error("live count above capacity");

   a_write_state: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_CLR || state_ff == S_CMP))
      else $error("slot table written outside clear or probe");

   a_reserved_fast: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && start && start_reserved) |=> (state_ff == S_FIN))
      else $error("reserved key went to the table");
`endif

endmodule

@@ design/open_addressing_hash_set.sv @@
// Open-addressing hash set with tombstones: streaming top level.
// Item occupancy: a reserved key finishes without a probe, else P probes (1..2**ADDR_W),
// one slot-table read per probe cycle.
// The result passes through the S_FIN state into the output register once that register is free.
// Synchronous reset starts a clearing pass that empties every slot, with req_tready low.
// Depends on ohs_pkg, ohs_ram and ohs_ctrl.
module open_addressing_hash_set #(
   parameter int CAPACITY = 1024,
   parameter int KEY_BITS = 32
) (
   input  logic                                      clock,
   input  logic                                      reset,
   // req_tdata fields from bit 0: action[1:0], key[KEY_BITS-1:0], zero fill
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   input  logic [((2 + KEY_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // rsp_tdata fields from bit 0: status[2:0], item_count[CNT_W-1:0], zero fill
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   output logic [((3 + $clog2(CAPACITY + 1) + 7) / 8) * 8 - 1:0] rsp_tdata
);
   import ohs_pkg::*;

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int RSP_W  = ((3 + CNT_W + 7) / 8) * 8;

   // request unpack
   action_type          req_action;
   logic [KEY_BITS-1:0] req_key;
   logic                req_accept;

   assign req_action = req_tdata[1:0];
   assign req_key    = req_tdata[2 +: KEY_BITS];
   assign req_accept = req_tvalid && req_tready;

   // sequencer <-> slot table
   logic                ram_we;
   logic [ADDR_W-1:0]   ram_waddr;
   logic [KEY_BITS-1:0] ram_wdata;
   logic [ADDR_W-1:0]   ram_raddr;
   logic [KEY_BITS-1:0] ram_rdata;

   fin_type             fin;
   logic                fin_take;
   logic [CNT_W-1:0]    live_count;
   logic                ctrl_idle;

   ohs_ram #(
      .WIDTH (KEY_BITS),
      .DEPTH (CAPACITY)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   ohs_ctrl #(
      .CAPACITY (CAPACITY),
      .KEY_BITS (KEY_BITS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (req_accept),
      .start_action (req_action),
      .start_key    (req_key),
      .idle         (ctrl_idle),
      .fin          (fin),
      .fin_take     (fin_take),
      .live_count   (live_count),
      .ram_we       (ram_we),
      .ram_waddr    (ram_waddr),
      .ram_wdata    (ram_wdata),
      .ram_raddr    (ram_raddr),
      .ram_rdata    (ram_rdata)
   );

   // Output register: lets the next item start while a result waits downstream.
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff;
   logic [CNT_W-1:0] rsp_count_ff;

   assign req_tready = ctrl_idle;
   assign fin_take   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fin.valid && fin_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (fin.valid && fin_take) begin
         rsp_status_ff <= fin.status;
         rsp_count_ff  <= live_count;   // count after this item's update
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_count_ff, rsp_status_ff});

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("sequencer ready right after taking an item");

   a_result_waits: assert property (@(posedge clock) disable iff (reset)
      (fin.valid && !fin_take) |=> fin.valid)
      else $error("finished result dropped while output register full");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (fin.valid && fin_take) |=> rsp_tvalid)
      else $error("finished result not presented");
`endif

endmodule
